@@ hw/rtl/hcbd_pkg.sv @@
// hcbd_pkg: shared types, constants and the hex digit decode for the
// chunked body decoder. No dependencies.
package hcbd_pkg;

    localparam int SIZE_BITS  = 24;   // chunk size accumulator width
    localparam int TOTAL_BITS = 16;   // running payload total width
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;   // total_len port width
    localparam int KIND_W     = 2;
    localparam int HEX_W      = 4;    // bits carried by one hex digit

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE_FIRST = 3'd0,
        PH_SIZE_MORE  = 3'd1,
        PH_EXT        = 3'd2,
        PH_SIZE_LF    = 3'd3,
        PH_DATA       = 3'd4,
        PH_DATA_CR    = 3'd5,
        PH_DATA_LF    = 3'd6,
        PH_DRAIN      = 3'd7
    } phase_t;

    typedef struct packed {
        logic             ok;
        logic [HEX_W-1:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = HEX_W'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = HEX_W'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = HEX_W'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ hw/rtl/http_chunked_body_decoder.sv @@
// channel  | handshake             | fields
// ---------+-----------------------+--------------------------
// input    | in_valid / in_stall   | in_byte, in_last
// output   | out_valid / out_stall | kind, out_byte, total_len
//
// one byte per clock while out_stall does not hold the result register:
// input register, one step of parse logic, result register.
// a byte that yields no result simply leaves the result register empty.
// rst_n is asynchronous and returns the parser to the first size digit.
// in_stall rises only when the input register is full and the result
// register is held by out_stall.
//
// file holds the decoder top level; depends on hcbd_pkg.
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] out_byte,
    output logic [LEN_W-1:0]  total_len
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [SIZE_BITS-1:0]  remain_reg, remain_next;
    logic [SIZE_BITS-1:0]  accum_reg, accum_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic consume;
    logic take_in;

    // step results
    phase_t                s_phase;
    logic [SIZE_BITS-1:0]  s_remain, s_accum;
    logic [TOTAL_BITS-1:0] s_total, s_total_inc;
    logic [SIZE_BITS-1:0]  s_remain_dec;
    logic                  s_res, s_err, s_clear;
    logic [KIND_W-1:0]     s_kind;
    logic [BYTE_W-1:0]     s_byte;
    logic [LEN_W-1:0]      s_len;
    hex_t                  hx;
    logic                  size_ovf;

    assign consume = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !consume;
    assign take_in = in_valid && !in_stall;

    assign in_valid_next = take_in || (in_valid_reg && !consume);

    assign hx           = hex_decode(byte_reg);
    assign size_ovf     = |accum_reg[SIZE_BITS-1 -: HEX_W];
    assign s_total_inc  = total_reg + TOTAL_BITS'(1);
    assign s_remain_dec = remain_reg - SIZE_BITS'(1);

    always_comb
    begin
        s_phase  = phase_reg;
        s_remain = remain_reg;
        s_accum  = accum_reg;
        s_total  = total_reg;
        s_res    = 1'b0;
        s_err    = 1'b0;
        s_clear  = 1'b0;
        s_kind   = KIND_DATA;
        s_byte   = '0;
        s_len    = LEN_W'(total_reg);

        case (phase_reg)
            PH_SIZE_FIRST, PH_SIZE_MORE:
            begin
                if (hx.ok)
                begin
                    if (size_ovf)
                    begin
                        s_err = 1'b1;
                    end
                    else
                    begin
                        s_accum = {accum_reg[SIZE_BITS-HEX_W-1:0], hx.val};
                        s_phase = PH_SIZE_MORE;
                        s_err   = last_reg;
                    end
                end
                else if (phase_reg == PH_SIZE_FIRST)
                begin
                    // empty size line
                    s_err = 1'b1;
                end
                else
                begin
                    s_phase = (byte_reg == CH_CR) ? PH_SIZE_LF : PH_EXT;
                    s_err   = last_reg;
                end
            end
            PH_EXT:
            begin
                if (byte_reg == CH_CR)
                begin
                    s_phase = PH_SIZE_LF;
                end
                s_err = last_reg;
            end
            PH_SIZE_LF:
            begin
                if (byte_reg != CH_LF || last_reg)
                begin
                    s_err = 1'b1;
                end
                else
                begin
                    s_remain = accum_reg;
                    s_accum  = '0;
                    s_phase  = (accum_reg == '0) ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (last_reg || (&total_reg))
                begin
                    s_err = 1'b1;
                end
                else
                begin
                    s_total  = s_total_inc;
                    s_remain = s_remain_dec;
                    if (s_remain_dec == '0)
                    begin
                        s_phase = PH_DATA_CR;
                    end
                    s_res  = 1'b1;
                    s_kind = KIND_DATA;
                    s_byte = byte_reg;
                    s_len  = LEN_W'(s_total_inc);
                end
            end
            PH_DATA_CR:
            begin
                if (byte_reg != CH_CR || last_reg)
                begin
                    s_err = 1'b1;
                end
                else
                begin
                    s_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (byte_reg != CH_LF)
                begin
                    s_err = 1'b1;
                end
                else if (last_reg)
                begin
                    s_res   = 1'b1;
                    s_kind  = KIND_DONE;
                    s_clear = 1'b1;
                end
                else
                begin
                    s_phase = PH_SIZE_FIRST;
                end
            end
            PH_DRAIN:
            begin
                s_clear = last_reg;
            end
            default:
            begin
                s_phase = PH_SIZE_FIRST;
            end
        endcase

        // error result carries the total held before this byte
        if (s_err)
        begin
            s_res   = 1'b1;
            s_kind  = KIND_ERR;
            s_byte  = '0;
            s_len   = LEN_W'(total_reg);
            s_total = total_reg;
            s_phase = PH_DRAIN;
            s_clear = last_reg;
        end

        if (s_clear)
        begin
            s_phase  = PH_SIZE_FIRST;
            s_remain = '0;
            s_accum  = '0;
            s_total  = '0;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        accum_next     = accum_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        obyte_next     = obyte_reg;
        len_next       = len_reg;
        if (consume)
        begin
            phase_next     = s_phase;
            remain_next    = s_remain;
            accum_next     = s_accum;
            total_next     = s_total;
            out_valid_next = s_res;
            kind_next      = s_kind;
            obyte_next     = s_byte;
            len_next       = s_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SIZE_FIRST;
            remain_reg    <= '0;
            accum_reg     <= '0;
            total_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            accum_reg     <= accum_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        kind_reg  <= kind_next;
        obyte_reg <= obyte_next;
        len_reg   <= len_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = obyte_reg;
    assign total_len = len_reg;

endmodule

@@ hw/rtl/hcbd_checker.sv @@
// hcbd_checker: port-level assertions for the chunked body decoder, and
// the bind that attaches them to the top level. Depends on hcbd_pkg.
module hcbd_checker
    import hcbd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [BYTE_W-1:0] in_byte,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_stall,
    input logic [KIND_W-1:0] kind,
    input logic [BYTE_W-1:0] out_byte,
    input logic [LEN_W-1:0]  total_len
);

    // only the three defined result codes appear
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_DATA || kind == KIND_DONE || kind == KIND_ERR))
        else $error("undefined result kind");

    // done and error items carry no byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DATA) |-> out_byte == '0)
        else $error("non-payload item with nonzero byte");

    // a payload item always counts itself
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DATA) |-> total_len != '0)
        else $error("payload item with zero total");

    // payload items back to back step the total by one
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && kind == KIND_DATA)
        |=> (!(out_valid && kind == KIND_DATA)
             || total_len == $past(total_len) + LEN_W'(1)))
        else $error("payload total did not advance by one");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind)
            && $stable(out_byte) && $stable(total_len)))
        else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
